FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion that a condition never shows outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/core/lfdt_pkg.sv
`timescale 1ns / 1ps

package lfdt_pkg;

  // Field widths of the request and result words.
  localparam int OP_W       = 2;
  localparam int IN_IDX_W   = 8;
  localparam int IN_HND_W   = 32;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_HND_W  = 32;
  localparam int KIND_W     = 2;

  // Slots examined per cycle by the free-slot scan.
  localparam int GROUP_BITS = 32;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_REG    = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREG  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BADF = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Command kinds after classification in the front part.
  typedef enum logic [KIND_W-1:0] {
    KIND_REG    = 2'd0,
    KIND_UNREG  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_FAIL   = 2'd3
  } cmd_kind_e;

endpackage

FILE: rtl/core/lfdt_front.sv
`timescale 1ns / 1ps

module lfdt_front
  import lfdt_pkg::*;
#(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 32,
  parameter int IDX_W       = $clog2(SLOTS)
) (
  input  logic [OP_W-1:0]        op_i,
  input  logic [IN_IDX_W-1:0]    index_i,
  input  logic [IN_HND_W-1:0]    handle_i,
  output cmd_kind_e              kind_o,
  output logic [IDX_W-1:0]       idx_o,
  output logic [HANDLE_BITS-1:0] hnd_o
);

  // The stored handle is the request handle cut to the table's handle width.
  assign hnd_o = HANDLE_BITS'(handle_i);
  assign idx_o = IDX_W'(index_i);

  // Requests that fail whatever the table holds are marked here already.
  always_comb begin
    unique case (op_i)
      OP_REG: begin
        kind_o = (hnd_o == '0) ? KIND_FAIL : KIND_REG;
      end
      OP_UNREG: begin
        kind_o = (int'(index_i) >= SLOTS) ? KIND_FAIL : KIND_UNREG;
      end
      OP_LOOKUP: begin
        kind_o = (int'(index_i) >= SLOTS) ? KIND_FAIL : KIND_LOOKUP;
      end
      default: begin
        kind_o = KIND_FAIL;
      end
    endcase
  end

endmodule

FILE: rtl/core/lfdt_queue.sv
`timescale 1ns / 1ps

module lfdt_queue #(
  parameter int WIDTH = 42
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  // Two-entry queue between the front and the back part.
  logic [WIDTH-1:0] ent_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = ent_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill level update.
  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/core/lfdt_back.sv
`timescale 1ns / 1ps

module lfdt_back
  import lfdt_pkg::*;
#(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 32,
  parameter int IDX_W       = $clog2(SLOTS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  cmd_kind_e              cmd_kind_i,
  input  logic [IDX_W-1:0]       cmd_idx_i,
  input  logic [HANDLE_BITS-1:0] cmd_hnd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output status_e                out_status_o,
  output logic [OUT_IDX_W-1:0]   out_idx_o,
  output logic [OUT_HND_W-1:0]   out_hnd_o
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int GRP_W = (SLOTS < GROUP_BITS) ? SLOTS : GROUP_BITS;
  localparam int NG    = (SLOTS + GRP_W - 1) / GRP_W;
  localparam int GI_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PE_W  = $clog2(GRP_W);
  localparam int OCC_W = NG * GRP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  cmd_kind_e              kind_q, kind_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [HANDLE_BITS-1:0] hnd_q, hnd_d;
  logic [GI_W-1:0]        grp_q, grp_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [OCC_W-1:0]       occ_q, occ_d;

  logic                   out_vld_q, out_vld_d;
  status_e                out_st_q, out_st_d;
  logic [OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [OUT_HND_W-1:0]   out_hnd_q, out_hnd_d;

  // Slot store: one write and one registered read port.
  logic [HANDLE_BITS-1:0] mem_q [SLOTS];
  logic [HANDLE_BITS-1:0] rdata_q;
  logic                   rd_en;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [HANDLE_BITS-1:0] wdata;

  logic [GRP_W-1:0]       occ_grp;
  logic [GRP_W-1:0]       free_m;
  logic [PE_W-1:0]        pe;
  logic                   any_free;
  logic                   last_grp;
  logic [IDX_W-1:0]       slot_found;
  logic [IDX_W-1:0]       slot_append;
  logic                   out_free;

  assign out_free = !out_vld_q || out_ready_i;

  // Free slots of the current group that lie below the high-water count.
  assign occ_grp = occ_q[grp_q*GRP_W +: GRP_W];

  always_comb begin
    free_m = '0;
    pe     = '0;
    for (int b = 0; b < GRP_W; b++) begin
      free_m[b] = ~occ_grp[b] && ((int'(grp_q) * GRP_W + b) < int'(cnt_q));
    end
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (free_m[b]) begin
        pe = PE_W'(b);
      end
    end
  end

  assign any_free    = |free_m;
  assign last_grp    = ((int'(grp_q) + 1) * GRP_W) >= int'(cnt_q);
  assign slot_found  = IDX_W'(int'(grp_q) * GRP_W + int'(pe));
  assign slot_append = IDX_W'(cnt_q);

  // Sequencer: dispatch, group scan, and slot read completion.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    hnd_d       = hnd_q;
    grp_d       = grp_q;
    cnt_d       = cnt_q;
    occ_d       = occ_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_idx_d   = out_idx_q;
    out_hnd_d   = out_hnd_q;
    cmd_ready_o = 1'b0;
    rd_en       = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = hnd_q;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          kind_d = cmd_kind_i;
          idx_d  = cmd_idx_i;
          hnd_d  = cmd_hnd_i;
          grp_d  = '0;
          unique case (cmd_kind_i)
            KIND_REG: begin
              state_d = S_SCAN;
            end
            KIND_UNREG, KIND_LOOKUP: begin
              if (CNT_W'(cmd_idx_i) < cnt_q) begin
                rd_en   = 1'b1;
                state_d = S_READ;
              end else begin
                out_vld_d = 1'b1;
                out_st_d  = ST_BADF;
                out_idx_d = '0;
                out_hnd_d = '0;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              out_st_d  = ST_BADF;
              out_idx_d = '0;
              out_hnd_d = '0;
            end
          endcase
        end
      end

      S_READ: begin
        if (out_free) begin
          state_d   = S_IDLE;
          out_vld_d = 1'b1;
          out_idx_d = '0;
          if (rdata_q == '0) begin
            out_st_d  = ST_BADF;
            out_hnd_d = '0;
          end else begin
            out_st_d  = ST_OK;
            out_hnd_d = OUT_HND_W'(rdata_q);
            if (kind_q == KIND_UNREG) begin
              we           = 1'b1;
              waddr        = idx_q;
              wdata        = '0;
              occ_d[idx_q] = 1'b0;
            end
          end
        end
      end

      S_SCAN: begin
        if (any_free) begin
          if (out_free) begin
            we                = 1'b1;
            waddr             = slot_found;
            wdata             = hnd_q;
            occ_d[slot_found] = 1'b1;
            state_d           = S_IDLE;
            out_vld_d         = 1'b1;
            out_st_d          = ST_OK;
            out_idx_d         = OUT_IDX_W'(slot_found);
            out_hnd_d         = '0;
          end
        end else if (last_grp) begin
          if (out_free) begin
            state_d   = S_IDLE;
            out_vld_d = 1'b1;
            out_hnd_d = '0;
            if (cnt_q == CNT_W'(SLOTS)) begin
              out_st_d  = ST_FULL;
              out_idx_d = '0;
            end else begin
              we                 = 1'b1;
              waddr              = slot_append;
              wdata              = hnd_q;
              occ_d[slot_append] = 1'b1;
              cnt_d              = cnt_q + CNT_W'(1);
              out_st_d           = ST_OK;
              out_idx_d          = OUT_IDX_W'(slot_append);
            end
          end
        end else begin
          grp_d = grp_q + GI_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      grp_q     <= '0;
      cnt_q     <= '0;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      grp_q     <= grp_d;
      cnt_q     <= cnt_d;
      occ_q     <= occ_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    idx_q     <= idx_d;
    hnd_q     <= hnd_d;
    out_st_q  <= out_st_d;
    out_idx_q <= out_idx_d;
    out_hnd_q <= out_hnd_d;
  end

  // Slot store write port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Slot store read port.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[cmd_idx_i];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;
  assign out_idx_o    = out_idx_q;
  assign out_hnd_o    = out_hnd_q;

endmodule

FILE: rtl/core/lowest_free_descriptor_table.sv
`timescale 1ns / 1ps

// Descriptor table of SLOTS entries that hands out the lowest free descriptor for a
// nonzero handle, and unregisters or looks up a descriptor below the high-water count.
// Requests enter a two-word queue, are registered there, and are carried out one at a
// time by the back part, which holds one finished result word in an output register;
// while that word waits, the back part takes no new request. A request that fails on
// its fields alone, or names a descriptor at or above the count, is answered straight
// from the idle state. Any other unregister or lookup passes through a read state,
// because the slot store read is registered. A register passes through the scan state,
// where the free-slot scan visits one group of 32 slots at a time until it finds a slot
// or reaches the count. The scan always visits at least one group, and at most
// max(1, ceil(count / 32)) groups. The slot store needs no clearing pass after reset:
// only slots below the count are ever read, and each of those has been written.

module lowest_free_descriptor_table
  import lfdt_pkg::*;
#(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // index_in[7:0], handle_in[39:8]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // index_out[5:0], handle_out[37:6], zero[39:38]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMD_W = KIND_W + IDX_W + HANDLE_BITS;

  cmd_kind_e              f_kind;
  logic [IDX_W-1:0]       f_idx;
  logic [HANDLE_BITS-1:0] f_hnd;
  logic [CMD_W-1:0]       q_rd_data;
  logic                   q_rd_valid;
  logic                   q_rd_ready;
  status_e                out_status;
  logic [OUT_IDX_W-1:0]   out_idx;
  logic [OUT_HND_W-1:0]   out_hnd;

  // Front part: classify the incoming word.
  lfdt_front #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS),
    .IDX_W       (IDX_W)
  ) u_front (
    .op_i     (s_axis_tuser),
    .index_i  (s_axis_tdata[IN_IDX_W-1:0]),
    .handle_i (s_axis_tdata[IN_IDX_W +: IN_HND_W]),
    .kind_o   (f_kind),
    .idx_o    (f_idx),
    .hnd_o    (f_hnd)
  );

  // Command queue between the two parts.
  lfdt_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_data_i  ({f_kind, f_idx, f_hnd}),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_data_o  (q_rd_data)
  );

  // Back part: table state and result register.
  lfdt_back #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_rd_valid),
    .cmd_ready_o  (q_rd_ready),
    .cmd_kind_i   (cmd_kind_e'(q_rd_data[CMD_W-1 -: KIND_W])),
    .cmd_idx_i    (q_rd_data[HANDLE_BITS +: IDX_W]),
    .cmd_hnd_i    (q_rd_data[HANDLE_BITS-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_idx_o    (out_idx),
    .out_hnd_o    (out_hnd)
  );

  assign m_axis_tdata = {2'b00, out_hnd, out_idx};
  assign m_axis_tuser = out_status;

endmodule

FILE: rtl/core/lfdt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // Words taken in but not yet answered.
  logic [2:0] pend_q, pend_d;
  logic       s_acc, m_acc;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign m_acc  = m_axis_tvalid && m_axis_tready;
  assign pend_d = pend_q + 3'(s_acc) - 3'(m_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result word holds its contents.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Every result answers an earlier request.
  `ASSERT_CLK(a_no_spurious, clk_i, rst_ni, m_axis_tvalid |-> pend_q != 3'd0, "result without request")

  // A failed request carries neither descriptor nor handle.
  `ASSERT_CLK(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata == 40'd0, "error result with payload")

  // A good result gives a descriptor or a handle, never both.
  `ASSERT_NEVER(a_ok_exclusive, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == 2'd0 && m_axis_tdata[5:0] != 6'd0 && m_axis_tdata[37:6] != 32'd0, "descriptor and handle both set")

endmodule

bind lowest_free_descriptor_table lfdt_checker u_lfdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
